// ===== hdl/dsp2_pkg.sv =====
// ----------------------------------------------------------------------------
// dsp2_pkg: shared types and constants for double_scale_by_power_of_two
// Field widths, IEEE-754 binary64 constants and stage payload structs.
// ----------------------------------------------------------------------------
package dsp2_pkg;

  localparam int unsigned ExpW   = 11;
  localparam int unsigned FracW  = 52;
  localparam int unsigned MantW  = 53;
  // working exponent: covers -5051 .. +7046
  localparam int unsigned WExpW  = 14;

  localparam logic [ExpW-1:0]  ExpAllOnes = 11'h7FF;
  localparam logic signed [WExpW-1:0] ShiftLimit = 14'sd5000;
  localparam logic signed [WExpW-1:0] MaxSubShift = 14'sd53;

  // stage 1 -> stage 2
  typedef struct packed {
    logic                    pass;      // operand returned as is
    logic [63:0]             raw;
    logic                    sign;
    logic [FracW-1:0]        frac;
    logic                    subn;
    logic signed [WExpW-1:0] n;         // clamped adjustment
    logic [ExpW-1:0]         e;
  } s1_t;

  // stage 2 -> stage 3
  typedef struct packed {
    logic                    pass;
    logic [63:0]             raw;
    logic                    sign;
    logic [FracW-1:0]        frac;
    logic signed [WExpW-1:0] e;         // final biased exponent plus adjustment
  } s2_t;

  // stage 3 -> output
  typedef struct packed {
    logic [63:0] bits;
    logic        err;
  } res_t;

endpackage

// ===== hdl/dsp2_unpack.sv =====
// ----------------------------------------------------------------------------
// dsp2_unpack: operand decode and adjustment clamp
// Splits the operand into fields and saturates the exponent shift.
// ----------------------------------------------------------------------------
module dsp2_unpack (
  input  logic        [63:0]            value_bits,
  input  logic signed [31:0]            exponent_shift,
  output dsp2_pkg::s1_t                 s1
);

  logic [dsp2_pkg::ExpW-1:0] e;

  always_comb begin
    e = value_bits[62:52];
    s1.raw  = value_bits;
    s1.pass = (e == dsp2_pkg::ExpAllOnes) || (value_bits[62:0] == 63'd0);
    s1.sign = value_bits[63];
    s1.frac = value_bits[51:0];
    s1.subn = (e == '0);
    s1.e    = e;
    if (exponent_shift > 32'sd5000) begin
      s1.n = dsp2_pkg::ShiftLimit;
    end else if (exponent_shift < -32'sd5000) begin
      s1.n = -dsp2_pkg::ShiftLimit;
    end else begin
      s1.n = exponent_shift[dsp2_pkg::WExpW-1:0];
    end
  end

endmodule

// ===== hdl/dsp2_norm.sv =====
// ----------------------------------------------------------------------------
// dsp2_norm: subnormal normalize and exponent add
// Leading-zero count over the fraction, shift left, then add the adjustment.
// ----------------------------------------------------------------------------
module dsp2_norm (
  input  dsp2_pkg::s1_t s1,
  output dsp2_pkg::s2_t s2
);

  logic [5:0]                       lz;
  logic [dsp2_pkg::FracW-1:0]       sh;
  logic signed [dsp2_pkg::WExpW-1:0] eb;

  always_comb begin
    lz = 6'd0;
    // count leading zeros in frac; hidden bit lands at position 52
    for (int i = 0; i < dsp2_pkg::FracW; i++) begin
      if (s1.frac[i]) lz = 6'(dsp2_pkg::FracW - i);
    end
    if (s1.subn) begin
      sh = s1.frac << lz;
      eb = 14'sd1 - $signed({8'd0, lz});
    end else begin
      sh = s1.frac;
      eb = $signed({3'd0, s1.e});
    end
    s2.pass = s1.pass;
    s2.raw  = s1.raw;
    s2.sign = s1.sign;
    s2.frac = sh;
    s2.e    = eb + s1.n;
  end

endmodule

// ===== hdl/dsp2_round.sv =====
// ----------------------------------------------------------------------------
// dsp2_round: range check, denormalize and round to nearest-even
// ----------------------------------------------------------------------------
module dsp2_round (
  input  dsp2_pkg::s2_t  s2,
  output dsp2_pkg::res_t res
);

  logic signed [dsp2_pkg::WExpW-1:0] shs;
  logic [5:0]                        sh;
  logic [dsp2_pkg::MantW-1:0]        mant, kept, rest, half, mask;
  logic [dsp2_pkg::MantW-1:0]        rnd;

  always_comb begin
    shs  = 14'sd1 - s2.e;
    sh   = shs[5:0];
    mant = {1'b1, s2.frac};
    kept = mant >> sh;
    mask = (53'd1 << sh) - 53'd1;
    rest = mant & mask;
    half = 53'd1 << (sh - 6'd1);
    rnd  = kept;
    if (rest > half || (rest == half && kept[0])) rnd = kept + 53'd1;

    if (s2.pass) begin
      res.bits = s2.raw;
      res.err  = 1'b0;
    end else if (s2.e >= 14'sd2047) begin
      res.bits = {s2.sign, dsp2_pkg::ExpAllOnes, 52'd0};
      res.err  = 1'b1;
    end else if (s2.e > 14'sd0) begin
      res.bits = {s2.sign, s2.e[10:0], s2.frac};
      res.err  = 1'b0;
    end else if (shs > dsp2_pkg::MaxSubShift) begin
      res.bits = {s2.sign, 63'd0};
      res.err  = 1'b1;
    end else begin
      // a carry into bit 52 gives the lowest normal exponent
      res.bits = {s2.sign, 10'd0, rnd};
      res.err  = (rnd == '0);
    end
  end

endmodule

// ===== hdl/double_scale_by_power_of_two.sv =====
// ----------------------------------------------------------------------------
// double_scale_by_power_of_two: binary64 x * 2^n with range flag
//
// channel | dir | tdata fields (low bit up)
// s_axis  | in  | value_bits[63:0], exponent_shift[95:64]
// m_axis  | out | result_bits[63:0], range_error[64], zero fill to 72
//
// One transfer per cycle sustained while m_axis_tready stays high; an accepted
// input passes the s1, s2 and r registers in order before it is offered on m_axis.
// Stages: decode/clamp, normalize/exponent add, round.
// A stall freezes a valid stage only when every stage after it is valid too; empty stages still fill.
// Synchronous reset clears the valid bits only.
// ----------------------------------------------------------------------------
module double_scale_by_power_of_two (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // value_bits, exponent_shift
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // result_bits, range_error, zeros
);

  dsp2_pkg::s1_t  s1_c, s1;
  dsp2_pkg::s2_t  s2_c, s2;
  dsp2_pkg::res_t r_c, r;
  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  assign adv3 = !v3 || m_axis_tready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign s_axis_tready = adv1;

  dsp2_unpack u_unpack (
    .value_bits    (s_axis_tdata[63:0]),
    .exponent_shift($signed(s_axis_tdata[95:64])),
    .s1            (s1_c)
  );
  dsp2_norm  u_norm  (.s1(s1), .s2(s2_c));
  dsp2_round u_round (.s2(s2), .res(r_c));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= s_axis_tvalid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) s1 <= s1_c;
    if (adv2) s2 <= s2_c;
    if (adv3) r  <= r_c;
  end

  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = {7'd0, r.err, r.bits};

endmodule

// ===== hdl/dsp2_checker.sv =====
// ----------------------------------------------------------------------------
// dsp2_checker: port-level checks for double_scale_by_power_of_two
// ----------------------------------------------------------------------------
module dsp2_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [95:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed during stall");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_axis_tdata[71:65] == 7'd0 || !m_axis_tvalid)
    else $error("nonzero fill bits");

  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && m_axis_tready ##1 m_axis_tready
      ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing after three cycles");

endmodule

bind double_scale_by_power_of_two dsp2_checker u_dsp2_checker (.*);
